// ===== sv/kbq_pkg.sv =====
// kbq_pkg: shared types, codes and reset values for the keypad event queue
// no dependencies; used by kbq_ctrl, kbq_datapath and the top level
`default_nettype none

package kbq_pkg;

  // default queue depth in bytes (one slot is always left empty)
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int TIME_W     = 32;
  localparam int CODE_W     = 8;
  localparam int OUT_W      = 16;

  localparam logic [OUT_W-1:0] MERGE_FLAG = 16'hF000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CODE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_CODE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CODE   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEFT    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIDDLE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_RIGHT   = 4'd7;

  // configuration reset values
  localparam logic [TIME_W-1:0] RST_LONG_MS      = 32'd1000;
  localparam logic [CODE_W-1:0] RST_RELEASE_CODE = 8'd240;
  localparam logic [CODE_W-1:0] RST_LEFT_CODE    = 8'd107;
  localparam logic [CODE_W-1:0] RST_MIDDLE_CODE  = 8'd90;
  localparam logic [CODE_W-1:0] RST_RIGHT_CODE   = 8'd116;
  localparam logic [CODE_W-1:0] RST_LONG_LEFT    = 8'd108;
  localparam logic [CODE_W-1:0] RST_LONG_MIDDLE  = 8'd91;
  localparam logic [CODE_W-1:0] RST_LONG_RIGHT   = 8'd117;

  // opcodes
  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // buttons
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_MIDDLE = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;

  // long press phases
  localparam logic [1:0] PH_SHORT = 2'd0;
  localparam logic [1:0] PH_LONG  = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  // push value select
  localparam logic [1:0] PS_MARKER = 2'd0;
  localparam logic [1:0] PS_BTN    = 2'd1;
  localparam logic [1:0] PS_LONG   = 2'd2;

  // peek result kinds
  localparam logic [1:0] PK_ZERO      = 2'd0;
  localparam logic [1:0] PK_DATA      = 2'd1;
  localparam logic [1:0] PK_FLAG      = 2'd2;
  localparam logic [1:0] PK_FLAG_DATA = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       btn_clr;
    logic       btn_inc;
    logic       edge_time;
    logic       tick_eval;
    logic       push;
    logic [1:0] push_sel;
    logic       rd_issue;
    logic       rd_far;
    logic       pop_adv;
    logic       flag_set;
    logic       rd_load_data;
    logic       rd_load_flag;
    logic       pk_load;
    logic [1:0] pk_kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       lvl;
    logic       btn_valid;
    logic       btn_last;
    logic       empty;
    logic       next_is_write;
    logic       is_marker;
    logic       released;
    logic       is_long;
    logic [1:0] phase;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/kbq_ctrl.sv =====
// kbq_ctrl: sequencing state machine of the keypad event queue
// depends on kbq_pkg for the command and status structs and codes
`default_nettype none

module kbq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire kbq_pkg::status_t st,
  output kbq_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  out_valid
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_EDGE_MARK = 4'd2;
  localparam logic [3:0] S_EDGE_CODE = 4'd3;
  localparam logic [3:0] S_TICK      = 4'd4;
  localparam logic [3:0] S_TICK_MARK = 4'd5;
  localparam logic [3:0] S_TICK_LONG = 4'd6;
  localparam logic [3:0] S_POP_RD    = 4'd7;
  localparam logic [3:0] S_POP_CHK   = 4'd8;
  localparam logic [3:0] S_PEEK0     = 4'd9;
  localparam logic [3:0] S_PEEK1     = 4'd10;
  localparam logic [3:0] S_PEEK2     = 4'd11;
  localparam logic [3:0] S_OUT       = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       held_long;

  assign held_long = !st.released && st.is_long;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          kbq_pkg::OP_EDGE: begin
            if (st.btn_valid) begin
              cmd.edge_time = 1'b1;
              state_nxt     = st.lvl ? S_EDGE_CODE : S_EDGE_MARK;
            end else begin
              state_nxt = S_PEEK0;
            end
          end
          kbq_pkg::OP_TICK: begin
            cmd.btn_clr = 1'b1;
            state_nxt   = S_TICK;
          end
          kbq_pkg::OP_READ: state_nxt = S_POP_RD;
          kbq_pkg::OP_NONE: state_nxt = S_PEEK0;
          default:          state_nxt = S_PEEK0;
        endcase
      end
      S_EDGE_MARK: begin
        cmd.push     = 1'b1;
        cmd.push_sel = kbq_pkg::PS_MARKER;
        state_nxt    = S_EDGE_CODE;
      end
      S_EDGE_CODE: begin
        cmd.push     = 1'b1;
        cmd.push_sel = kbq_pkg::PS_BTN;
        state_nxt    = S_PEEK0;
      end
      S_TICK: begin
        cmd.tick_eval = 1'b1;
        cmd.push      = held_long && (st.phase == kbq_pkg::PH_SHORT);
        cmd.push_sel  = kbq_pkg::PS_LONG;
        if (held_long && (st.phase == kbq_pkg::PH_LONG)) begin
          state_nxt = S_TICK_MARK;
        end else if (st.btn_last) begin
          state_nxt = S_PEEK0;
        end else begin
          cmd.btn_inc = 1'b1;
        end
      end
      S_TICK_MARK: begin
        cmd.push     = 1'b1;
        cmd.push_sel = kbq_pkg::PS_MARKER;
        state_nxt    = S_TICK_LONG;
      end
      S_TICK_LONG: begin
        cmd.push     = 1'b1;
        cmd.push_sel = kbq_pkg::PS_LONG;
        if (st.btn_last) begin
          state_nxt = S_PEEK0;
        end else begin
          cmd.btn_inc = 1'b1;
          state_nxt   = S_TICK;
        end
      end
      S_POP_RD: begin
        if (st.empty) begin
          cmd.rd_load_flag = 1'b1;
          state_nxt        = S_PEEK0;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.pop_adv  = 1'b1;
          state_nxt    = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (st.is_marker) begin
          cmd.flag_set = 1'b1;
          state_nxt    = S_POP_RD;
        end else begin
          cmd.rd_load_data = 1'b1;
          state_nxt        = S_PEEK0;
        end
      end
      S_PEEK0: begin
        if (st.empty) begin
          cmd.pk_load = 1'b1;
          cmd.pk_kind = kbq_pkg::PK_ZERO;
          state_nxt   = S_OUT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_PEEK1;
        end
      end
      S_PEEK1: begin
        if (!st.is_marker) begin
          cmd.pk_load = 1'b1;
          cmd.pk_kind = kbq_pkg::PK_DATA;
          state_nxt   = S_OUT;
        end else if (st.next_is_write) begin
          cmd.pk_load = 1'b1;
          cmd.pk_kind = kbq_pkg::PK_FLAG;
          state_nxt   = S_OUT;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.rd_far   = 1'b1;
          state_nxt    = S_PEEK2;
        end
      end
      S_PEEK2: begin
        cmd.pk_load = 1'b1;
        cmd.pk_kind = kbq_pkg::PK_FLAG_DATA;
        state_nxt   = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

`default_nettype wire

// ===== sv/kbq_datapath.sv =====
// kbq_datapath: configuration registers, button timers, byte queue and result registers
// depends on kbq_pkg; driven by commands from kbq_ctrl
`default_nettype none

module kbq_datapath #(
  parameter int QUEUE_DEPTH = kbq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire kbq_pkg::cmd_t                  cmd,
  output kbq_pkg::status_t                    st,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [1:0]                     in_button,
  input  wire logic                           in_pin_level,
  input  wire logic [kbq_pkg::TIME_W-1:0]     in_now_ms,
  input  wire logic                           cfg_we,
  input  wire logic [kbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kbq_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [kbq_pkg::OUT_W-1:0]           out_read_code,
  output logic [kbq_pkg::OUT_W-1:0]           out_peek_code,
  output logic                                out_available
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam int TW = kbq_pkg::TIME_W;
  localparam int CW = kbq_pkg::CODE_W;
  localparam int OW = kbq_pkg::OUT_W;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // configuration
  logic [TW-1:0] long_ms_r;
  logic [CW-1:0] release_code_r;
  logic [CW-1:0] btn_code_r  [3];
  logic [CW-1:0] long_code_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ms_r      <= kbq_pkg::RST_LONG_MS;
      release_code_r <= kbq_pkg::RST_RELEASE_CODE;
      btn_code_r[0]  <= kbq_pkg::RST_LEFT_CODE;
      btn_code_r[1]  <= kbq_pkg::RST_MIDDLE_CODE;
      btn_code_r[2]  <= kbq_pkg::RST_RIGHT_CODE;
      long_code_r[0] <= kbq_pkg::RST_LONG_LEFT;
      long_code_r[1] <= kbq_pkg::RST_LONG_MIDDLE;
      long_code_r[2] <= kbq_pkg::RST_LONG_RIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kbq_pkg::CFG_LONG_MS:      long_ms_r      <= cfg_data[TW-1:0];
        kbq_pkg::CFG_RELEASE_CODE: release_code_r <= cfg_data[CW-1:0];
        kbq_pkg::CFG_LEFT_CODE:    btn_code_r[0]  <= cfg_data[CW-1:0];
        kbq_pkg::CFG_MIDDLE_CODE:  btn_code_r[1]  <= cfg_data[CW-1:0];
        kbq_pkg::CFG_RIGHT_CODE:   btn_code_r[2]  <= cfg_data[CW-1:0];
        kbq_pkg::CFG_LONG_LEFT:    long_code_r[0] <= cfg_data[CW-1:0];
        kbq_pkg::CFG_LONG_MIDDLE:  long_code_r[1] <= cfg_data[CW-1:0];
        kbq_pkg::CFG_LONG_RIGHT:   long_code_r[2] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]    op_r;
  logic          lvl_r;
  logic [TW-1:0] now_r;
  logic [1:0]    btn_sel_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_opcode;
      lvl_r <= in_pin_level;
      now_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_sel_r <= kbq_pkg::BTN_LEFT;
    end else if (cmd.latch) begin
      btn_sel_r <= in_button;
    end else if (cmd.btn_clr) begin
      btn_sel_r <= kbq_pkg::BTN_LEFT;
    end else if (cmd.btn_inc) begin
      btn_sel_r <= btn_sel_r + 2'd1;
    end
  end

  // per button timing
  logic [TW-1:0] press_time_r   [3];
  logic [TW-1:0] release_time_r [3];
  logic [1:0]    phase_r        [3];
  logic [TW-1:0] press_cur;
  logic [TW-1:0] release_cur;
  logic [1:0]    phase_cur;
  logic [CW-1:0] btn_code_cur;
  logic [CW-1:0] long_code_cur;
  logic          btn_valid;
  logic [TW-1:0] long_limit;

  assign btn_valid = (btn_sel_r != 2'd3);

  always_comb begin
    unique case (btn_sel_r)
      kbq_pkg::BTN_LEFT: begin
        press_cur = press_time_r[0]; release_cur = release_time_r[0];
        phase_cur = phase_r[0]; btn_code_cur = btn_code_r[0];
        long_code_cur = long_code_r[0];
      end
      kbq_pkg::BTN_MIDDLE: begin
        press_cur = press_time_r[1]; release_cur = release_time_r[1];
        phase_cur = phase_r[1]; btn_code_cur = btn_code_r[1];
        long_code_cur = long_code_r[1];
      end
      kbq_pkg::BTN_RIGHT: begin
        press_cur = press_time_r[2]; release_cur = release_time_r[2];
        phase_cur = phase_r[2]; btn_code_cur = btn_code_r[2];
        long_code_cur = long_code_r[2];
      end
      default: begin
        press_cur = '0; release_cur = '0; phase_cur = kbq_pkg::PH_SHORT;
        btn_code_cur = '0; long_code_cur = '0;
      end
    endcase
  end

  // limit wraps modulo 2^32
  assign long_limit = press_cur + long_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 3; b++) begin
        press_time_r[b]   <= '0;
        release_time_r[b] <= TW'(1);
        phase_r[b]        <= kbq_pkg::PH_SHORT;
      end
    end else begin
      if (cmd.edge_time && btn_valid) begin
        if (lvl_r) begin
          press_time_r[btn_sel_r] <= now_r;
        end else begin
          release_time_r[btn_sel_r] <= now_r;
        end
      end
      if (cmd.tick_eval && btn_valid) begin
        if (st.released) begin
          phase_r[btn_sel_r] <= kbq_pkg::PH_SHORT;
        end else if (st.is_long) begin
          if (phase_cur == kbq_pkg::PH_SHORT) begin
            phase_r[btn_sel_r] <= kbq_pkg::PH_LONG;
          end else if (phase_cur == kbq_pkg::PH_LONG) begin
            phase_r[btn_sel_r] <= kbq_pkg::PH_DONE;
          end
        end
      end
    end
  end

  // byte queue; only written slots are ever read, so no clearing is needed
  logic [CW-1:0] queue_mem [QUEUE_DEPTH];
  logic [IW-1:0] wr_idx_r;
  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] wr_next;
  logic [IW-1:0] rd_next;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] push_val;
  logic          push_ok;
  logic [CW-1:0] mem_q_r;

  assign wr_next = nxt(wr_idx_r);
  assign rd_next = nxt(rd_idx_r);
  assign rd_addr = cmd.rd_far ? nxt(rd_next) : rd_next;
  assign push_ok = cmd.push && (wr_next != rd_idx_r);

  always_comb begin
    unique case (cmd.push_sel)
      kbq_pkg::PS_MARKER: push_val = release_code_r;
      kbq_pkg::PS_BTN:    push_val = btn_code_cur;
      kbq_pkg::PS_LONG:   push_val = long_code_cur;
      default:            push_val = release_code_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      queue_mem[wr_next] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      mem_q_r <= queue_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
    end else begin
      if (push_ok) begin
        wr_idx_r <= wr_next;
      end
      if (cmd.pop_adv) begin
        rd_idx_r <= rd_next;
      end
    end
  end

  // result registers
  logic          flag_r;
  logic [OW-1:0] rd_code_r;
  logic [OW-1:0] pk_code_r;
  logic          avail_r;
  logic [OW-1:0] flag_word;

  assign flag_word = flag_r ? kbq_pkg::MERGE_FLAG : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= 1'b0;
      rd_code_r <= '0;
      pk_code_r <= '0;
      avail_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        flag_r    <= 1'b0;
        rd_code_r <= '0;
      end else begin
        if (cmd.flag_set) begin
          flag_r <= 1'b1;
        end
        if (cmd.rd_load_flag) begin
          rd_code_r <= flag_word;
        end else if (cmd.rd_load_data) begin
          rd_code_r <= flag_word | {{(OW-CW){1'b0}}, mem_q_r};
        end
      end
      if (cmd.pk_load) begin
        unique case (cmd.pk_kind)
          kbq_pkg::PK_ZERO: begin
            pk_code_r <= '0;
            avail_r   <= 1'b0;
          end
          kbq_pkg::PK_DATA: begin
            pk_code_r <= {{(OW-CW){1'b0}}, mem_q_r};
            avail_r   <= 1'b1;
          end
          kbq_pkg::PK_FLAG: begin
            pk_code_r <= kbq_pkg::MERGE_FLAG;
            avail_r   <= 1'b0;
          end
          kbq_pkg::PK_FLAG_DATA: begin
            pk_code_r <= kbq_pkg::MERGE_FLAG | {{(OW-CW){1'b0}}, mem_q_r};
            avail_r   <= 1'b1;
          end
          default: begin
            pk_code_r <= '0;
            avail_r   <= 1'b0;
          end
        endcase
      end
    end
  end

  assign out_read_code = rd_code_r;
  assign out_peek_code = pk_code_r;
  assign out_available = avail_r;

  // status back to the controller
  always_comb begin
    st               = '0;
    st.op            = op_r;
    st.lvl           = lvl_r;
    st.btn_valid     = btn_valid;
    st.btn_last      = (btn_sel_r == kbq_pkg::BTN_RIGHT);
    st.empty         = (wr_idx_r == rd_idx_r);
    st.next_is_write = (rd_next == wr_idx_r);
    st.is_marker     = (mem_q_r == release_code_r);
    st.released      = (press_cur < release_cur);
    st.is_long       = (now_r > long_limit);
    st.phase         = phase_cur;
  end

endmodule

`default_nettype wire

// ===== sv/three_button_keypad_event_queue_top.sv =====
// three_button_keypad_event_queue_top: one command in, one result strobe out
// the controller steps one queue push or one registered queue read per cycle
// throughput: one item at a time, next start taken the cycle after out_valid
// synchronous active-low reset empties the queue and restores register defaults
// depends on kbq_pkg, kbq_ctrl and kbq_datapath
`default_nettype none

module three_button_keypad_event_queue_top #(
  parameter int QUEUE_DEPTH = kbq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // command side: a transfer happens when start is high and busy is low
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [1:0]                     in_button,
  input  wire logic                           in_pin_level,
  input  wire logic [kbq_pkg::TIME_W-1:0]     in_now_ms,
  // result side: one transfer per out_valid cycle, never held off
  output logic                                out_valid,
  output logic [kbq_pkg::OUT_W-1:0]           out_read_code,
  output logic [kbq_pkg::OUT_W-1:0]           out_peek_code,
  output logic                                out_available,
  // register writes, only while idle
  input  wire logic                           cfg_we,
  input  wire logic [kbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kbq_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between the sequencer and the datapath
  kbq_pkg::cmd_t    cmd;
  kbq_pkg::status_t st;

  // sequencer: decode, pushes, pop loop over release markers, peek lookahead
  kbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: registers, button timers, ring queue with registered read
  kbq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_opcode     (in_opcode),
    .in_button     (in_button),
    .in_pin_level  (in_pin_level),
    .in_now_ms     (in_now_ms),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_read_code (out_read_code),
    .out_peek_code (out_peek_code),
    .out_available (out_available)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for the three-button keypad event queue
// needs kbq_pkg and three_button_keypad_event_queue_top; holds its own queue predictor

module tb;
  import kbq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 170;
  // an index past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  // one result transfer
  typedef struct packed {
    logic [OUT_W-1:0] read_code;
    logic [OUT_W-1:0] peek_code;
    logic             available;
  } keypad_report_t;

  localparam keypad_report_t NO_REPORT = '0;

  // one row of the directed script: a command, or a register write
  typedef struct packed {
    bit                    is_cfg;
    logic [1:0]            op;
    logic [1:0]            btn;
    logic                  lvl;
    logic [TIME_W-1:0]     now_ms;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    has_want;
    keypad_report_t        want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_opcode = OP_NONE;
  logic [1:0]            in_button = BTN_LEFT;
  logic                  in_pin_level = 1'b0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_read_code;
  logic [OUT_W-1:0]      out_peek_code;
  logic                  out_available;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  three_button_keypad_event_queue_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_button     (in_button),
    .in_pin_level  (in_pin_level),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_read_code (out_read_code),
    .out_peek_code (out_peek_code),
    .out_available (out_available),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: private copy of the registers and of the queue state
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] long_ms;
  logic [CODE_W-1:0] rel_code;
  logic [CODE_W-1:0] btn_code [3];
  logic [CODE_W-1:0] long_code [3];

  logic [CODE_W-1:0] key_ring [QDEPTH];
  int                wr_slot;
  int                rd_slot;
  logic [TIME_W-1:0] press_t [3];
  logic [TIME_W-1:0] rel_t [3];
  logic [1:0]        hold_phase [3];

  // results still owed by the block, oldest first
  keypad_report_t    owed_reports [$];

  // run bookkeeping
  int n_items = 0;
  int n_edges = 0;
  int n_ticks = 0;
  int n_reads = 0;
  int n_results = 0;
  int n_bad = 0;
  int n_settings = 0;
  int idle_pct = 0;
  logic [TIME_W-1:0] cur_ms = '0;
  bit held [3];

  function automatic int next_slot(input int i);
    return (i + 1 >= QDEPTH) ? 0 : i + 1;
  endfunction

  // a push that would catch up with the read side is lost
  function automatic void push_key(input logic [CODE_W-1:0] v);
    int n;
    n = next_slot(wr_slot);
    if (n != rd_slot) begin
      key_ring[n] = v;
      wr_slot = n;
    end
  endfunction

  // head of queue, a leading marker folded in as the merge flag
  function automatic logic [OUT_W-1:0] head_code();
    int i;
    if (wr_slot == rd_slot) return '0;
    i = next_slot(rd_slot);
    if (key_ring[i] == rel_code) begin
      if (i == wr_slot) return MERGE_FLAG;
      i = next_slot(i);
      return MERGE_FLAG | {8'h00, key_ring[i]};
    end
    return {8'h00, key_ring[i]};
  endfunction

  // a lone trailing marker is not yet a complete code
  function automatic logic head_ready();
    int i;
    if (wr_slot == rd_slot) return 1'b0;
    i = next_slot(rd_slot);
    if (key_ring[i] == rel_code) return i != wr_slot;
    return 1'b1;
  endfunction

  // pops markers until a real code turns up or the queue runs dry
  function automatic logic [OUT_W-1:0] pop_key();
    logic [OUT_W-1:0] flag;
    flag = '0;
    while (wr_slot != rd_slot) begin
      rd_slot = next_slot(rd_slot);
      if (key_ring[rd_slot] != rel_code) return flag | {8'h00, key_ring[rd_slot]};
      flag = MERGE_FLAG;
    end
    return flag;
  endfunction

  function automatic void tick_button(input int b, input logic [TIME_W-1:0] now_ms);
    logic [TIME_W-1:0] limit_ms;
    limit_ms = press_t[b] + long_ms;
    if (press_t[b] < rel_t[b]) begin
      hold_phase[b] = PH_SHORT;
    end else if (now_ms > limit_ms) begin
      if (hold_phase[b] == PH_SHORT) begin
        push_key(long_code[b]);
        hold_phase[b] = PH_LONG;
      end else if (hold_phase[b] == PH_LONG) begin
        push_key(rel_code);
        push_key(long_code[b]);
        hold_phase[b] = PH_DONE;
      end
    end
  endfunction

  function automatic keypad_report_t keypad_step(input logic [1:0] op, input logic [1:0] btn,
                                                 input logic lvl, input logic [TIME_W-1:0] now_ms);
    keypad_report_t r;
    r = '0;
    case (op)
      OP_EDGE: begin
        if (btn <= BTN_RIGHT) begin
          if (!lvl) begin
            push_key(rel_code);
            rel_t[btn] = now_ms;
          end else begin
            press_t[btn] = now_ms;
          end
          push_key(btn_code[btn]);
        end
      end
      OP_TICK: begin
        for (int b = 0; b < 3; b++) tick_button(b, now_ms);
      end
      OP_READ: begin
        r.read_code = pop_key();
      end
      default: ;
    endcase
    r.peek_code = head_code();
    r.available = head_ready();
    return r;
  endfunction

  function automatic void keypad_reset();
    long_ms      = RST_LONG_MS;
    rel_code     = RST_RELEASE_CODE;
    btn_code[0]  = RST_LEFT_CODE;
    btn_code[1]  = RST_MIDDLE_CODE;
    btn_code[2]  = RST_RIGHT_CODE;
    long_code[0] = RST_LONG_LEFT;
    long_code[1] = RST_LONG_MIDDLE;
    long_code[2] = RST_LONG_RIGHT;
    for (int i = 0; i < QDEPTH; i++) key_ring[i] = '0;
    wr_slot = 0;
    rd_slot = 0;
    for (int b = 0; b < 3; b++) begin
      press_t[b]    = '0;
      rel_t[b]      = 32'd1;
      hold_phase[b] = PH_SHORT;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LONG_MS:      long_ms      = val;
      CFG_RELEASE_CODE: rel_code     = val[CODE_W-1:0];
      CFG_LEFT_CODE:    btn_code[0]  = val[CODE_W-1:0];
      CFG_MIDDLE_CODE:  btn_code[1]  = val[CODE_W-1:0];
      CFG_RIGHT_CODE:   btn_code[2]  = val[CODE_W-1:0];
      CFG_LONG_LEFT:    long_code[0] = val[CODE_W-1:0];
      CFG_LONG_MIDDLE:  long_code[1] = val[CODE_W-1:0];
      CFG_LONG_RIGHT:   long_code[2] = val[CODE_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // one command transfer; inputs move on the falling edge, the transfer is
  // taken at the first rising edge with busy low
  task automatic send_cmd(input logic [1:0] op, input logic [1:0] btn, input logic lvl,
                          input logic [TIME_W-1:0] now_ms, input bit has_want,
                          input keypad_report_t want);
    keypad_report_t predicted;
    // random gaps before the next command
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    in_opcode    <= op;
    in_button    <= btn;
    in_pin_level <= lvl;
    in_now_ms    <= now_ms;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer taken: step the predictor
    predicted = keypad_step(op, btn, lvl, now_ms);
    owed_reports.push_back(has_want ? want : predicted);
    n_items++;
    case (op)
      OP_EDGE: n_edges++;
      OP_TICK: n_ticks++;
      OP_READ: n_reads++;
      default: ;
    endcase
  endtask

  // stop issuing and let every owed result come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (owed_reports.size() != 0) @(posedge clk);
    // next command is only taken the cycle after the strobe
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // new register set for each random phase, extremes on the first two
  task automatic program_phase(input int p);
    logic [TIME_W-1:0]     lms;
    logic [CFG_DATA_W-1:0] rel;
    logic [CFG_DATA_W-1:0] bc [3];
    logic [CFG_DATA_W-1:0] lc [3];
    drain();
    rel = $urandom;
    for (int b = 0; b < 3; b++) begin
      bc[b] = $urandom;
      lc[b] = $urandom;
    end
    case (p)
      0: begin
        // zero limit, marker 0 clashing with every long code
        lms = '0;
        rel = '0;
        for (int b = 0; b < 3; b++) begin
          bc[b] = 32'hFFFF_FFFF;
          lc[b] = 32'hFFFF_FF00;
        end
      end
      1: begin
        // widest limit, power-on codes
        lms   = 32'hFFFF_FFFF;
        rel   = RST_RELEASE_CODE;
        bc[0] = RST_LEFT_CODE;
        bc[1] = RST_MIDDLE_CODE;
        bc[2] = RST_RIGHT_CODE;
        lc[0] = RST_LONG_LEFT;
        lc[1] = RST_LONG_MIDDLE;
        lc[2] = RST_LONG_RIGHT;
      end
      2: lms = $urandom_range(1, 300);
      3: lms = $urandom;
      4: lms = $urandom_range(100, 2000);
      default: lms = 32'd100;
    endcase
    // marker equal to one of the key codes, so codes get read as markers
    if (p == 2 || p == 5) begin
      if ($urandom_range(0, 1)) rel = bc[$urandom_range(0, 2)];
      else rel = lc[$urandom_range(0, 2)];
    end
    write_reg(CFG_LONG_MS, lms);
    write_reg(CFG_RELEASE_CODE, rel);
    write_reg(CFG_LEFT_CODE, bc[0]);
    write_reg(CFG_MIDDLE_CODE, bc[1]);
    write_reg(CFG_RIGHT_CODE, bc[2]);
    write_reg(CFG_LONG_LEFT, lc[0]);
    write_reg(CFG_LONG_MIDDLE, lc[1]);
    write_reg(CFG_LONG_RIGHT, lc[2]);
    write_reg(CFG_UNUSED, $urandom);
    end_writes();
  endtask

  // mostly forward time, often landing right on a long-press boundary
  function automatic logic [TIME_W-1:0] next_time();
    int k;
    int b;
    k = $urandom_range(0, 9);
    b = $urandom_range(0, 2);
    if (k < 4) cur_ms = cur_ms + $urandom_range(0, 50);
    else if (k < 7) cur_ms = press_t[b] + long_ms + $urandom_range(0, 2) - 32'd1;
    else if (k < 9) cur_ms = cur_ms + $urandom_range(0, 5000);
    else cur_ms = $urandom;
    return cur_ms;
  endfunction

  // one random command; returns 0 for noise the block simply ignores
  task automatic send_random(output bit counted);
    int r;
    int b;
    logic lvl;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 8) begin
      // unused opcode or a pin edge on the missing fourth button
      counted = 1'b0;
      if (r < 4) send_cmd(OP_NONE, 2'($urandom), 1'($urandom), $urandom, 1'b0, NO_REPORT);
      else send_cmd(OP_EDGE, 2'd3, 1'($urandom), $urandom, 1'b0, NO_REPORT);
    end else if (r < 38) begin
      // well-formed press/release pairs, now and then a repeated level
      b = $urandom_range(0, 2);
      lvl = ($urandom_range(0, 9) == 0) ? 1'($urandom) : ~held[b];
      held[b] = lvl;
      send_cmd(OP_EDGE, 2'(b), lvl, next_time(), 1'b0, NO_REPORT);
    end else if (r < 68) begin
      send_cmd(OP_TICK, 2'($urandom), 1'($urandom), next_time(), 1'b0, NO_REPORT);
    end else begin
      send_cmd(OP_READ, 2'($urandom), 1'($urandom), $urandom, 1'b0, NO_REPORT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: every strobe is checked against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    keypad_report_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (owed_reports.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result transfer: read_code %h peek_code %h available %b",
                   out_read_code, out_peek_code, out_available);
      end else begin
        want = owed_reports.pop_front();
        if (out_read_code !== want.read_code || out_peek_code !== want.peek_code ||
            out_available !== want.available) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d mismatch: read_code %h/%h peek_code %h/%h available %b/%b",
                     n_results, want.read_code, out_read_code, want.peek_code,
                     out_peek_code, want.available, out_available);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  script_row_t script [23];
  int idle_by_phase [NUM_PHASES] = '{0, 54, 15, 54, 0, 15};

  initial begin
    int done;
    int wait_cycles;
    bit counted;

    // directed script starting from power-on register values; expectations typed in
    // only where they are plain from the reset state
    script = '{
      // read and unused opcode on an empty queue
      '{1'b0, OP_READ, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b1, 33'h0},
      '{1'b0, OP_NONE, 2'd3, 1'b1, 32'hFFFF_FFFF, CFG_LONG_MS, 32'd0, 1'b1, 33'h0},
      // tick with every button still released
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b1, 33'h0},
      // left press: the left code waits alone
      '{1'b0, OP_EDGE, BTN_LEFT, 1'b1, 32'd10, CFG_LONG_MS, 32'd0, 1'b1,
        {16'h0000, 16'd107, 1'b1}},
      // turn that byte into a lone trailing marker
      '{1'b1, OP_NONE, BTN_LEFT, 1'b0, 32'd0, CFG_RELEASE_CODE, 32'd107, 1'b0, NO_REPORT},
      '{1'b0, OP_NONE, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b1,
        {16'h0000, MERGE_FLAG, 1'b0}},
      // second marker behind the first
      '{1'b0, OP_EDGE, BTN_LEFT, 1'b1, 32'd20, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b1, OP_NONE, BTN_LEFT, 1'b0, 32'd0, CFG_RELEASE_CODE, 32'(RST_RELEASE_CODE),
        1'b0, NO_REPORT},
      '{1'b1, OP_NONE, BTN_LEFT, 1'b0, 32'd0, CFG_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
      // edge on the missing button
      '{1'b0, OP_EDGE, 2'd3, 1'b0, 32'd30, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      // left held: on the limit, just past it, second long tick, then done
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'd1020, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'd1021, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'd2000, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'd3000, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_EDGE, BTN_LEFT, 1'b0, 32'd3001, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      // timestamps at both ends, limit sum wrapping
      '{1'b0, OP_EDGE, BTN_MIDDLE, 1'b1, 32'hFFFF_FFFF, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_EDGE, BTN_RIGHT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'hFFFF_FFFF, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      // queue runs full here, the last push is lost
      '{1'b0, OP_TICK, BTN_LEFT, 1'b0, 32'hFFFF_FFFF, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      // reads, with markers merged in
      '{1'b0, OP_READ, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_READ, BTN_RIGHT, 1'b1, 32'hFFFF_FFFF, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_READ, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT},
      '{1'b0, OP_READ, BTN_LEFT, 1'b0, 32'd0, CFG_LONG_MS, 32'd0, 1'b0, NO_REPORT}
    };

    keypad_reset();
    for (int b = 0; b < 3; b++) held[b] = 1'b0;

    // synchronous reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    idle_pct = 0;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        write_reg(script[i].reg_idx, script[i].reg_val);
        end_writes();
      end else begin
        send_cmd(script[i].op, script[i].btn, script[i].lvl, script[i].now_ms,
                 script[i].has_want, script[i].want);
      end
    end

    // random phases, each with its own registers and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_phase(p);
      idle_pct = idle_by_phase[p];
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        send_random(counted);
        if (counted) done++;
      end
    end

    // wind down: collect the last results, then watch for strays
    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (owed_reports.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (owed_reports.size() != 0) begin
      n_bad++;
      $display("%0d results never arrived", owed_reports.size());
    end

    $display("sent %0d commands (%0d pin edges, %0d ticks, %0d reads) across %0d register sets",
             n_items, n_edges, n_ticks, n_reads, n_settings);
    $display("%0d result transfers checked, %0d mismatches", n_results, n_bad);
    if (n_bad == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kbq_pkg.sv
sv/kbq_ctrl.sv
sv/kbq_datapath.sv
sv/three_button_keypad_event_queue_top.sv
tb/tb.sv
